// ----- src/tdpt_pkg.sv -----
// Shared constants and types for the trial-division prime tester.
package tdpt_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;

   // Status that the remainder unit reports back to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
      logic rem_zero;
   } div_status_type;

endpackage

// ----- src/tdpt_chan_if.sv -----
// Valid/ready channel interfaces for the request and response sides.
interface tdpt_req_if #(
   parameter int VALUE_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] candidate;

   modport source (output valid, output candidate, input ready);
   modport sink   (input valid, input candidate, output ready);
endinterface

interface tdpt_rsp_if #(
   parameter int VALUE_WIDTH = 16
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] tested_value;
   logic                   is_prime;

   modport source (output valid, output tested_value, output is_prime, input ready);
   modport sink   (input valid, input tested_value, input is_prime, output ready);
endinterface

// ----- src/tdpt_divider.sv -----
// Bit-serial restoring remainder unit: one quotient bit per cycle.
module tdpt_divider
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT,
   parameter int DIV_WIDTH   = (VALUE_WIDTH + 1) / 2 + 1
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [VALUE_WIDTH-1:0] dividend,
   input  logic [DIV_WIDTH-1:0]   divisor,
   output div_status_type         status
);

   localparam int CNT_WIDTH = $clog2(VALUE_WIDTH);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] shift_ff, shift_in;
   logic [DIV_WIDTH-1:0]   rem_ff, rem_in;
   logic [DIV_WIDTH-1:0]   dvsr_ff, dvsr_in;
   logic [DIV_WIDTH:0]     trial;
   logic [DIV_WIDTH:0]     diff;

   // Bring down the next dividend bit and subtract if it fits.
   assign trial = {rem_ff, shift_ff[VALUE_WIDTH-1]};
   assign diff  = trial - {1'b0, dvsr_ff};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dvsr_in  = dvsr_ff;
      if (start) begin
         busy_in  = 1'b1;
         cnt_in   = CNT_WIDTH'(VALUE_WIDTH - 1);
         shift_in = dividend;
         rem_in   = '0;
         dvsr_in  = divisor;
      end else if (busy_ff) begin
         shift_in = shift_ff << 1;
         rem_in   = (trial >= {1'b0, dvsr_ff}) ? diff[DIV_WIDTH-1:0] : trial[DIV_WIDTH-1:0];
         cnt_in   = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff   <= cnt_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dvsr_ff  <= dvsr_in;
   end

   assign status.busy     = busy_ff;
   assign status.done     = done_ff;
   assign status.rem_zero = (rem_ff == '0);

endmodule

// ----- src/trial_division_prime_test_top.sv -----
// Top level of the trial-division prime tester: sequencer around a single remainder unit.
//
// Takes one unsigned candidate per request transfer and returns one response
// transfer carrying the candidate and a prime flag. Divisors run 2, 3, 4, ...
// while divisor squared stays at or below the candidate; the test stops at
// the first divisor that leaves no remainder. Zero and one are reported not
// prime. Every trial divisor runs VALUE_WIDTH shift steps in the bit-serial
// remainder unit, then a report, with a square bound check before it. A
// 16-bit prime near 65,535 tries 254 divisors; a candidate below 4 tries
// none. The block holds req ready low from the request transfer until the
// response transfer; the response stays valid until taken.
// No reset pass is needed; there is no stored table.
module trial_division_prime_test_top
   import tdpt_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tdpt_req_if.sink   req_chan,
   tdpt_rsp_if.source rsp_chan
);

   // Divisor never needs more than ceil(W/2)+1 bits; its square fits W+2.
   localparam int DIV_WIDTH = (VALUE_WIDTH + 1) / 2 + 1;
   localparam int SQ_WIDTH  = VALUE_WIDTH + 2;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_CHECK = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_DONE  = 4'b1000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] value_ff, value_in;
   logic [DIV_WIDTH-1:0]   divisor_ff, divisor_in;
   logic [SQ_WIDTH-1:0]    square_ff, square_in;
   logic                   prime_ff, prime_in;
   logic                   div_start;
   logic                   req_xfer;
   logic                   rsp_xfer;
   logic                   square_fits;
   div_status_type         div_status;

   assign req_xfer    = req_chan.valid && req_chan.ready;
   assign rsp_xfer    = rsp_chan.valid && rsp_chan.ready;
   assign square_fits = (square_ff <= SQ_WIDTH'(value_ff));

   // Sequencer: check the square bound, run one remainder, advance the divisor.
   always_comb begin
      state_in   = state_ff;
      value_in   = value_ff;
      divisor_in = divisor_ff;
      square_in  = square_ff;
      prime_in   = prime_ff;
      div_start  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               value_in   = req_chan.candidate;
               divisor_in = DIV_WIDTH'(2);
               square_in  = SQ_WIDTH'(4);
               // Drop zero and one straight to a not-prime answer.
               if (req_chan.candidate < VALUE_WIDTH'(2)) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (square_fits) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               // No divisor up to the square root: prime.
               prime_in = 1'b1;
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (div_status.done) begin
               if (div_status.rem_zero) begin
                  prime_in = 1'b0;
                  state_in = ST_DONE;
               end else begin
                  // (d+1)^2 = d^2 + 2d + 1
                  square_in  = square_ff + SQ_WIDTH'({divisor_ff, 1'b1});
                  divisor_in = divisor_ff + 1'b1;
                  state_in   = ST_CHECK;
               end
            end
         end
         ST_DONE: begin
            if (rsp_xfer) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      value_ff   <= value_in;
      divisor_ff <= divisor_in;
      square_ff  <= square_in;
      prime_ff   <= prime_in;
   end

   tdpt_divider #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .DIV_WIDTH   (DIV_WIDTH)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (value_ff),
      .divisor  (divisor_ff),
      .status   (div_status)
   );

   // Hold the answer on the response side until it is taken.
   assign req_chan.ready        = (state_ff == ST_IDLE);
   assign rsp_chan.valid        = (state_ff == ST_DONE);
   assign rsp_chan.tested_value = value_ff;
   assign rsp_chan.is_prime     = prime_ff;

   // Never launch a remainder while the unit is still working.
   assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("remainder unit started while busy");

   // A remainder is only run for a divisor whose square fits the candidate.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> (square_ff <= SQ_WIDTH'(value_ff)))
      else $error("divisor beyond square root under test");

   // Zero and one must never come back as prime.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.is_prime) |-> (value_ff >= VALUE_WIDTH'(2)))
      else $error("value below two reported prime");

   // The divider result arrives only while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DIV))
      else $error("remainder result with no divide in flight");

   // A request transfer always starts work.
   assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> (state_ff != ST_IDLE))
      else $error("accepted request dropped");

endmodule

// ----- verif/tb_trial_division_prime_test_top.sv -----
// Self-checking testbench for the trial-division prime tester top level.
module tb_trial_division_prime_test_top
   import tdpt_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WIDTH = VALUE_WIDTH_DEFAULT;

   // Worst correct run: 140 items, each a prime near the top of the range,
   // plus sender gaps, receiver stalls and the long hold-off; the limit
   // allows several times that.
   localparam longint unsigned CYCLE_LIMIT = 64'd4_000_000;

   // Length of the long receiver hold-off used to back up the block.
   localparam int LONG_HOLD_CYCLES = 2000;

   // Cycles to watch for stray responses once nothing is outstanding.
   localparam int DRAIN_CYCLES = 50;

   typedef struct {
      logic [WIDTH-1:0] tested_value;
      logic             is_prime;
   } verdict_type;

   logic clock;
   logic reset;

   tdpt_req_if #(.VALUE_WIDTH(WIDTH)) req_chan ();
   tdpt_rsp_if #(.VALUE_WIDTH(WIDTH)) rsp_chan ();

   trial_division_prime_test_top #(
      .VALUE_WIDTH(WIDTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   // Verdicts owed by the block, oldest first.
   verdict_type     pending_verdicts[$];
   int              mismatch_count;
   longint unsigned cycle_count;

   // Sequencing flags shared between the test tasks and the receiver.
   bit steady_mode;          // no idling on either side
   bit long_hold_request;    // ask the receiver for one long hold-off

   // Clock: 20 ns period.
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Count cycles for the run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // Abort the run if it never finishes.
   initial begin
      while (cycle_count < CYCLE_LIMIT) @(posedge clock);
      $display("%0t: run limit of %0d cycles reached, %0d verdicts still owed",
               $time, CYCLE_LIMIT, pending_verdicts.size());
      $display("tb_trial_division_prime_test_top: FAIL");
      $finish;
   end

   // Compute the verdict for one candidate: trial divisors 2, 3, 4, ...
   // while the divisor squared stays at or below the candidate. Zero and one
   // fall out as not prime; two and three never enter the loop.
   function automatic verdict_type trial_division_verdict(input logic [WIDTH-1:0] candidate);
      verdict_type     verdict;
      longint unsigned value;
      longint unsigned divisor;
      verdict.tested_value = candidate;
      value = candidate;
      verdict.is_prime = (value >= 2);
      for (divisor = 2; verdict.is_prime && divisor * divisor <= value; divisor++) begin
         if (value % divisor == 0) begin
            verdict.is_prime = 1'b0;
         end
      end
      return verdict;
   endfunction

   // Offer one candidate and hold it until the block takes it. Valid stays
   // high after the transfer so a back-to-back item need not raise it again;
   // drop_request lowers it at the end of a burst.
   task automatic offer_candidate(input logic [WIDTH-1:0] candidate);
      int gap;
      if (!steady_mode && $urandom_range(0, 3) == 0) begin
         // Idle for a random burst; scramble the payload while valid is low.
         gap = $urandom_range(1, 5);
         req_chan.valid     <= 1'b0;
         req_chan.candidate <= WIDTH'($urandom);
         repeat (gap) @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.candidate <= candidate;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      // Transfer happened at this edge: the verdict is now owed.
      pending_verdicts.push_back(trial_division_verdict(candidate));
   endtask

   // Drop valid after the last transfer of a burst.
   task automatic drop_request();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   // Wait until every owed verdict has come back.
   task automatic wait_for_verdicts();
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // Compare one response transfer against the oldest owed verdict.
   task automatic check_verdict(input logic [WIDTH-1:0] tested_value, input logic is_prime);
      verdict_type owed;
      if (pending_verdicts.size() == 0) begin
         $display("%0t: response with nothing owed: tested_value %0d is_prime %0b",
                  $time, tested_value, is_prime);
         mismatch_count++;
      end else begin
         owed = pending_verdicts.pop_front();
         if (tested_value !== owed.tested_value) begin
            $display("%0t: tested_value mismatch: expected %0d actual %0d",
                     $time, owed.tested_value, tested_value);
            mismatch_count++;
         end
         if (is_prime !== owed.is_prime) begin
            $display("%0t: is_prime mismatch for %0d: expected %0b actual %0b",
                     $time, owed.tested_value, owed.is_prime, is_prime);
            mismatch_count++;
         end
      end
   endtask

   // Response side: check every transfer, then pick the next ready value.
   // Ready is stalled in random bursts, or held low for a long stretch when
   // a test asks for it so the block backs up into its request side.
   initial begin
      int hold_left;
      int stall_left;
      hold_left  = 0;
      stall_left = 0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            check_verdict(rsp_chan.tested_value, rsp_chan.is_prime);
         end
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            hold_left = LONG_HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_chan.ready <= 1'b0;
         end else if (!steady_mode && $urandom_range(0, 5) == 0) begin
            // Start a stall; stall_left holds its remaining length, this one not included.
            stall_left = $urandom_range(1, 5) - 1;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // Edges of the range and the special cases: zero and one, the smallest
   // primes, squares of primes that only fall at the last divisor, the
   // largest prime below the top and the all-ones and alternating patterns.
   task automatic test_corner_values();
      logic [WIDTH-1:0] corners[20];
      corners = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd9, 16'd25,
                  16'd49, 16'd97, 16'd7919, 16'd32749, 16'd32768, 16'h5555,
                  16'hAAAA, 16'd63001, 16'd65025, 16'd65521, 16'd65534, 16'hFFFF};
      foreach (corners[i]) begin
         offer_candidate(corners[i]);
      end
      drop_request();
      wait_for_verdicts();
   endtask

   // Random candidates, weighted toward small values so that slow primes
   // near the top of the range stay few. Products of two factors give composites
   // whose first divisor can come late.
   task automatic test_random_candidates(input int count);
      logic [WIDTH-1:0] candidate;
      int               pick;
      int               factor;
      repeat (count) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) begin
            candidate = WIDTH'($urandom_range(0, 255));
         end else if (pick < 70) begin
            candidate = WIDTH'($urandom_range(256, 4095));
         end else if (pick < 85) begin
            candidate = WIDTH'($urandom);
         end else begin
            factor    = $urandom_range(2, 255);
            candidate = WIDTH'(factor * $urandom_range(2, 65535 / factor));
         end
         offer_candidate(candidate);
      end
      drop_request();
      wait_for_verdicts();
   endtask

   // Hold the response side off for a long stretch while items keep coming,
   // so the block stalls its request side behind an untaken response.
   task automatic test_output_backpressure();
      long_hold_request = 1'b1;
      repeat (6) begin
         offer_candidate(WIDTH'($urandom_range(0, 1023)));
      end
      drop_request();
      wait_for_verdicts();
   endtask

   // Closing stretch: no idling on either side, items offered back to back.
   task automatic test_back_to_back();
      steady_mode = 1'b1;
      repeat (20) begin
         offer_candidate(WIDTH'($urandom_range(0, 2047)));
      end
      drop_request();
      wait_for_verdicts();
   endtask

   initial begin
      mismatch_count    = 0;
      cycle_count       = 0;
      steady_mode       = 1'b0;
      long_hold_request = 1'b0;
      reset              <= 1'b1;
      req_chan.valid     <= 1'b0;
      req_chan.candidate <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_values();
      test_random_candidates(94);
      test_output_backpressure();
      test_back_to_back();

      // Watch for stray responses after the last owed verdict.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_trial_division_prime_test_top: PASS");
      end else begin
         $display("tb_trial_division_prime_test_top: FAIL");
      end
      $finish;
   end

endmodule
